>>> rtl/core/plii_pkg.sv
// Shared types and constants for the piecewise linear interpolator.
`default_nettype none
package plii_pkg;
  localparam int unsigned MAX_POINTS = 7;
  localparam int unsigned MIN_POINTS = 2;
  localparam int unsigned DIV_STEPS  = 32;

  typedef enum logic [2:0] {
    REG_NUM_POINTS = 3'd0,
    REG_POINT_0    = 3'd1
  } reg_idx_e;

  // classified item from the front part
  typedef struct packed {
    logic [31:0] dx;
    logic [31:0] span;
    logic [31:0] mag;
    logic        neg;
    logic [31:0] out0;
    logic        hit;
    logic        zspan;
  } cls_t;

  // item inside the multiply/divide pipeline
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] word;
    logic [31:0] dvs;
    logic [31:0] out0;
    logic        neg;
    logic        hit;
    logic        use_q;
  } div_t;

  typedef struct packed {
    logic [31:0] mapped;
    logic        matched;
  } res_t;
endpackage
`default_nettype wire

>>> rtl/core/plii_front.sv
// Front part: breakpoint registers, segment match and operand setup.
`default_nettype none
module plii_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire  [2:0]           cfg_idx_i,
  input  wire  [63:0]          cfg_data_i,
  input  wire                  push,
  output logic                 full,
  input  wire  signed [31:0]   sample_i,
  input  wire                  q_full_i,
  output logic                 q_push_o,
  output plii_pkg::cls_t       q_data_o
);
  import plii_pkg::*;

  logic [2:0]  num_q;
  logic [63:0] pts_q [MAX_POINTS];
  logic        vld_q;
  cls_t        cls_q;
  cls_t        cls_d;
  logic [2:0]  n_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= 3'd2;
      for (int k = 0; k < MAX_POINTS; k++) pts_q[k] <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_NUM_POINTS) num_q <= cfg_data_i[2:0];
      else pts_q[cfg_idx_i - REG_POINT_0] <= cfg_data_i;
    end
  end

  always_comb begin
    logic signed [31:0] in0, in1, out0, out1;
    logic signed [32:0] dy;
    logic [32:0]        mag;
    if (num_q < 3'(MIN_POINTS))      n_eff = 3'(MIN_POINTS);
    else if (num_q > 3'(MAX_POINTS)) n_eff = 3'(MAX_POINTS);
    else                             n_eff = num_q;
    cls_d = '0;
    for (int k = 0; k < MAX_POINTS - 1; k++) begin
      in0  = pts_q[k][63:32];
      in1  = pts_q[k+1][63:32];
      out0 = pts_q[k][31:0];
      out1 = pts_q[k+1][31:0];
      dy   = 33'(out1) - 33'(out0);
      mag  = dy[32] ? 33'(-dy) : 33'(dy);
      if ((4'(k) + 4'd1 < {1'b0, n_eff}) && sample_i >= in0 && sample_i <= in1) begin
        cls_d.dx    = 32'(sample_i - in0);
        cls_d.span  = 32'(in1 - in0);
        cls_d.mag   = mag[31:0];
        cls_d.neg   = dy[32];
        cls_d.out0  = out0;
        cls_d.hit   = 1'b1;
        cls_d.zspan = (in0 == in1);
      end
    end
  end

  assign full     = vld_q & q_full_i;
  assign q_push_o = vld_q & ~q_full_i;
  assign q_data_o = cls_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (push && !full) begin
      vld_q <= 1'b1;
    end else if (q_push_o) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && !full) cls_q <= cls_d;
  end
endmodule
`default_nettype wire

>>> rtl/core/plii_queue.sv
// Two-entry queue between front and back parts.
`default_nettype none
module plii_queue (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             push_i,
  input  plii_pkg::cls_t  data_i,
  output logic            full_o,
  input  wire             pop_i,
  output logic            empty_o,
  output plii_pkg::cls_t  data_o
);
  import plii_pkg::*;

  cls_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end
endmodule
`default_nettype wire

>>> rtl/core/plii_back.sv
// Back part: multiply, pipelined restoring divide, result queue.
`default_nettype none
module plii_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 q_empty_i,
  input  plii_pkg::cls_t      q_data_i,
  output logic                q_pop_o,
  output logic                empty,
  input  wire                 pop,
  output logic signed [31:0]  mapped_o,
  output logic                matched_o
);
  import plii_pkg::*;

  logic       en;
  logic       mvld_q;
  div_t       mul_q;
  logic       vld_q [DIV_STEPS];
  div_t       stg_q [DIV_STEPS];
  res_t       oq_q  [2];
  logic       owp_q, orp_q;
  logic [1:0] ocnt_q;
  logic       owr;
  res_t       res;

  assign en      = ~(vld_q[DIV_STEPS-1] && ocnt_q == 2'd2);
  assign q_pop_o = en & ~q_empty_i;

  always_ff @(posedge clk_i) begin
    if (en) begin
      {mul_q.rem, mul_q.word} <= 64'(q_data_i.mag) * 64'(q_data_i.dx);
      mul_q.dvs   <= q_data_i.span;
      mul_q.out0  <= q_data_i.out0;
      mul_q.neg   <= q_data_i.neg;
      mul_q.hit   <= q_data_i.hit;
      mul_q.use_q <= q_data_i.hit & ~q_data_i.zspan;
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    div_t       src, nxt;
    logic [32:0] t;
    logic        ge;
    assign src = (i == 0) ? mul_q : stg_q[(i == 0) ? 0 : i-1];
    assign t   = {src.rem, src.word[31]};
    assign ge  = t >= {1'b0, src.dvs};
    always_comb begin
      nxt      = src;
      nxt.rem  = ge ? 32'(t - {1'b0, src.dvs}) : t[31:0];
      nxt.word = {src.word[30:0], ge};
    end
    always_ff @(posedge clk_i) begin
      if (en) stg_q[i] <= nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mvld_q <= 1'b0;
      for (int i = 0; i < DIV_STEPS; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      mvld_q   <= ~q_empty_i;
      vld_q[0] <= mvld_q;
      for (int i = 1; i < DIV_STEPS; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_comb begin
    logic [31:0] q;
    q = stg_q[DIV_STEPS-1].use_q ? stg_q[DIV_STEPS-1].word : '0;
    res.matched = stg_q[DIV_STEPS-1].hit;
    if (!stg_q[DIV_STEPS-1].hit)     res.mapped = '0;
    else if (stg_q[DIV_STEPS-1].neg) res.mapped = stg_q[DIV_STEPS-1].out0 - q;
    else                             res.mapped = stg_q[DIV_STEPS-1].out0 + q;
  end

  assign owr       = vld_q[DIV_STEPS-1] & en;
  assign empty     = ocnt_q == 2'd0;
  assign mapped_o  = oq_q[orp_q].mapped;
  assign matched_o = oq_q[orp_q].matched;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q  <= 1'b0;
      orp_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      if (owr) owp_q <= ~owp_q;
      if (pop && !empty) orp_q <= ~orp_q;
      ocnt_q <= ocnt_q + 2'(owr) - 2'(pop && !empty);
    end
  end

  always_ff @(posedge clk_i) begin
    if (owr) oq_q[owp_q] <= res;
  end

  a_ocnt: assert property (@(posedge clk_i) disable iff (!rst_ni) ocnt_q != 2'd3)
    else $error("result queue overflow");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |-> vld_q[DIV_STEPS-1])
    else $error("pipeline stalled without a waiting beat");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !owr) |=> ocnt_q == $past(ocnt_q) - 2'd1)
    else $error("result queue count mismatch");
endmodule
`default_nettype wire

>>> rtl/core/piecewise_linear_interpolator_unit.sv
// Path: front register, two-entry queue, multiply register, 32 divider stages,
// result queue. Throughput: one sample per cycle while full is low.
// The pipeline freezes only while the two-entry result queue is full.
// Reset: asynchronous, active low; num_points returns to 2, breakpoints to 0,
// all queues empty.
`default_nettype none
module piecewise_linear_interpolator_unit (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire  [2:0]          cfg_idx_i,
  input  wire  [63:0]         cfg_data_i,
  input  wire                 push,
  output logic                full,
  input  wire  signed [31:0]  sample_i,
  output logic                empty,
  input  wire                 pop,
  output logic signed [31:0]  mapped_o,
  output logic                matched_o
);
  import plii_pkg::*;

  logic q_full, q_push, q_empty, q_pop;
  cls_t q_wdata, q_rdata;

  plii_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .push, .full, .sample_i,
    .q_full_i(q_full), .q_push_o(q_push), .q_data_o(q_wdata)
  );

  plii_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(q_push), .data_i(q_wdata), .full_o(q_full),
    .pop_i(q_pop), .empty_o(q_empty), .data_o(q_rdata)
  );

  plii_back u_back (
    .clk_i, .rst_ni,
    .q_empty_i(q_empty), .q_data_i(q_rdata), .q_pop_o(q_pop),
    .empty, .pop, .mapped_o, .matched_o
  );
endmodule
`default_nettype wire
